/* src/ptl_pkg.sv */
// Shared types and constants for the plane track lifecycle block.
// No dependencies.
package ptl_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 12;
    localparam int STAT_W    = 2;
    localparam int FRAME_W   = 8;
    localparam int SCORE_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;
    localparam int DIV_STEPS = FRAME_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(256);
    localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

    typedef enum logic [MODE_W-1:0] {
        MODE_OBSERVE = 2'd0,
        MODE_CREATE  = 2'd1,
        MODE_EMPTY   = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_TENTATIVE = 2'd0,
        ST_TRACKING  = 2'd1,
        ST_LOCKED    = 2'd2,
        ST_LOST      = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_INLIERS = 2'd0,
        CFG_LOCK_FRAMES = 2'd1,
        CFG_MAX_UNSEEN  = 2'd2,
        CFG_NONE        = 2'd3
    } t_cfg_index;

    localparam logic [COUNT_W-1:0] MIN_INLIERS_RST = COUNT_W'(50);
    localparam logic [FRAME_W-1:0] LOCK_FRAMES_RST = FRAME_W'(10);
    localparam logic [FRAME_W-1:0] MAX_UNSEEN_RST  = FRAME_W'(30);

    function automatic logic [FRAME_W-1:0] sat_inc(input logic [FRAME_W-1:0] v);
        sat_inc = (v == FRAME_MAX) ? v : v + FRAME_W'(1);
    endfunction

endpackage

/* src/plane_track_lifecycle.sv */
// Plane track lifecycle table: per-slot status, counters and stability score.
// Depends on ptl_pkg (types, widths, codes, saturating increment).
//
// Each accepted request names a slot and a mode and answers with one result
// holding the slot's new contents; mode 3 is taken and dropped with no result.
// The block handles one request at a time: a request that needs no score
// division goes through accept, evaluate and result, and a seen frame on a
// tentative plane that does not lock also passes through a restoring
// divider for its score, which resolves one quotient bit per cycle.
// A stalled result is held until the stall is released. Tables reset to
// all slots lost with zeroed counts and score.
module plane_track_lifecycle (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [ptl_pkg::MODE_W-1:0]       i_mode,
    input  logic [ptl_pkg::SLOT_W-1:0]       i_slot,
    input  logic [ptl_pkg::COUNT_W-1:0]      i_inlier_count,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ptl_pkg::SLOT_W-1:0]       o_slot_out,
    output logic [ptl_pkg::STAT_W-1:0]       o_plane_status,
    output logic [ptl_pkg::FRAME_W-1:0]      o_stable_count,
    output logic [ptl_pkg::FRAME_W-1:0]      o_unseen_count,
    output logic [ptl_pkg::SCORE_W-1:0]      o_score_q8,
    output logic [ptl_pkg::COUNT_W-1:0]      o_last_inliers,
    input  logic                             i_cfg_we,
    input  logic [ptl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ptl_pkg::CFG_DAT_W-1:0]    i_cfg_data
);
    import ptl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                r_state, n_state;

    logic [COUNT_W-1:0]    r_min_inliers;
    logic [FRAME_W-1:0]    r_lock_frames;
    logic [FRAME_W-1:0]    r_max_unseen;

    t_status               r_status_tab [NUM_SLOTS];
    logic [FRAME_W-1:0]    r_stable_tab [NUM_SLOTS];
    logic [FRAME_W-1:0]    r_unseen_tab [NUM_SLOTS];
    logic [SCORE_W-1:0]    r_score_tab  [NUM_SLOTS];

    t_mode                 r_mode;
    logic [SLOT_W-1:0]     r_slot;
    logic [COUNT_W-1:0]    r_count;

    t_status               r_out_status, n_status;
    logic [FRAME_W-1:0]    r_out_stable, n_stable;
    logic [FRAME_W-1:0]    r_out_unseen, n_unseen;
    logic [SCORE_W-1:0]    r_out_score,  n_score;
    logic [COUNT_W-1:0]    r_out_inliers, n_inliers;
    logic                  n_div_need;

    logic [FRAME_W-1:0]    r_div_rem;
    logic [FRAME_W-1:0]    r_div_quo;
    logic [DIV_CNT_W-1:0]  r_div_cnt;

    t_status               cur_status;
    logic [FRAME_W-1:0]    cur_stable;
    logic [FRAME_W-1:0]    cur_unseen;
    logic [SCORE_W-1:0]    cur_score;
    logic [FRAME_W-1:0]    age_once;
    logic [FRAME_W-1:0]    age_twice;
    logic [FRAME_W-1:0]    stable_inc;
    logic [COUNT_W-1:0]    frame_count;
    logic                  seen;
    logic                  in_take;
    logic                  in_keep;

    logic [FRAME_W:0]      div_shift;
    logic                  div_ge;
    logic [FRAME_W:0]      div_diff;
    logic                  div_last;

    assign in_take = i_in_valid && (r_state == S_IDLE);
    assign in_keep = (t_mode'(i_mode) != MODE_UNUSED) && (32'(i_slot) < NUM_SLOTS);

    assign cur_status = r_status_tab[r_slot];
    assign cur_stable = r_stable_tab[r_slot];
    assign cur_unseen = r_unseen_tab[r_slot];
    assign cur_score  = r_score_tab[r_slot];

    assign age_once    = (r_mode == MODE_EMPTY) ? sat_inc(cur_unseen) : cur_unseen;
    assign age_twice   = sat_inc(age_once);
    assign stable_inc  = sat_inc(cur_stable);
    assign frame_count = (r_mode == MODE_OBSERVE) ? r_count : '0;
    assign seen        = frame_count >= r_min_inliers;

    // shared compare-subtract step of the score divider
    assign div_shift = {r_div_rem, 1'b0};
    assign div_ge    = div_shift >= {1'b0, r_lock_frames};
    assign div_diff  = div_shift - {1'b0, r_lock_frames};
    assign div_last  = r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1);

    always_comb begin
        n_status   = cur_status;
        n_stable   = cur_stable;
        n_unseen   = age_twice;
        n_score    = cur_score;
        n_inliers  = frame_count;
        n_div_need = 1'b0;
        if (r_mode == MODE_CREATE) begin
            n_status  = ST_TENTATIVE;
            n_stable  = '0;
            n_unseen  = '0;
            n_score   = '0;
            n_inliers = '0;
        end else if (seen) begin
            n_unseen = '0;
            unique case (cur_status)
                ST_TENTATIVE: begin
                    n_stable = stable_inc;
                    if (stable_inc >= r_lock_frames) begin
                        n_status = ST_LOCKED;
                        n_score  = SCORE_ONE;
                    end else begin
                        n_div_need = 1'b1;
                    end
                end
                ST_TRACKING: begin
                    n_stable = stable_inc;
                    if (stable_inc >= r_lock_frames) begin
                        n_status = ST_LOCKED;
                    end
                end
                ST_LOCKED: begin
                end
                ST_LOST: begin
                    n_status = ST_TRACKING;
                    n_stable = FRAME_W'(1);
                end
                default: begin
                end
            endcase
        end else begin
            if (cur_status == ST_LOCKED) begin
                n_status = ST_TRACKING;
                n_stable = '0;
            end else if (cur_status == ST_TRACKING) begin
                n_stable = '0;
            end
            if (age_twice > r_max_unseen) begin
                n_status = ST_LOST;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_take && in_keep) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = n_div_need ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_min_inliers <= MIN_INLIERS_RST;
            r_lock_frames <= LOCK_FRAMES_RST;
            r_max_unseen  <= MAX_UNSEEN_RST;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_status_tab[i] <= ST_LOST;
                r_stable_tab[i] <= '0;
                r_unseen_tab[i] <= '0;
                r_score_tab[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_MIN_INLIERS: r_min_inliers <= i_cfg_data;
                    CFG_LOCK_FRAMES: r_lock_frames <= i_cfg_data[FRAME_W-1:0];
                    CFG_MAX_UNSEEN:  r_max_unseen  <= i_cfg_data[FRAME_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_EVAL) begin
                r_status_tab[r_slot] <= n_status;
                r_stable_tab[r_slot] <= n_stable;
                r_unseen_tab[r_slot] <= n_unseen;
                if (!n_div_need) begin
                    r_score_tab[r_slot] <= n_score;
                end
            end
            if ((r_state == S_DIV) && div_last) begin
                r_score_tab[r_slot] <= {1'b0, r_div_quo[FRAME_W-2:0], div_ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode  <= t_mode'(i_mode);
            r_slot  <= i_slot;
            r_count <= i_inlier_count;
        end
        unique case (r_state)
            S_EVAL: begin
                r_out_status  <= n_status;
                r_out_stable  <= n_stable;
                r_out_unseen  <= n_unseen;
                r_out_score   <= n_score;
                r_out_inliers <= n_inliers;
                r_div_rem     <= n_stable;
                r_div_quo     <= '0;
                r_div_cnt     <= '0;
            end
            S_DIV: begin
                r_div_rem <= div_ge ? div_diff[FRAME_W-1:0] : div_shift[FRAME_W-1:0];
                r_div_quo <= {r_div_quo[FRAME_W-2:0], div_ge};
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                if (div_last) begin
                    r_out_score <= {1'b0, r_div_quo[FRAME_W-2:0], div_ge};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall     = r_state != S_IDLE;
    assign o_out_valid    = r_state == S_OUT;
    assign o_slot_out     = r_slot;
    assign o_plane_status = r_out_status;
    assign o_stable_count = r_out_stable;
    assign o_unseen_count = r_out_unseen;
    assign o_score_q8     = r_out_score;
    assign o_last_inliers = r_out_inliers;

endmodule

/* test/tb_plane_track_lifecycle.sv */
// Self-checking testbench for plane_track_lifecycle: random and directed requests.
// It predicts each slot update and compares it with the block's results.
// Depends on ptl_pkg and the plane_track_lifecycle RTL.
`timescale 1ns / 100ps

module tb_plane_track_lifecycle;
    import ptl_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLDOFF_LEN  = 400;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [STAT_W-1:0]  status;
        logic [FRAME_W-1:0] stable;
        logic [FRAME_W-1:0] unseen;
        logic [SCORE_W-1:0] score;
        logic [COUNT_W-1:0] inliers;
    } t_plane_update;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [MODE_W-1:0]    i_mode;
    logic [SLOT_W-1:0]    i_slot;
    logic [COUNT_W-1:0]   i_inlier_count;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [SLOT_W-1:0]    o_slot_out;
    logic [STAT_W-1:0]    o_plane_status;
    logic [FRAME_W-1:0]   o_stable_count;
    logic [FRAME_W-1:0]   o_unseen_count;
    logic [SCORE_W-1:0]   o_score_q8;
    logic [COUNT_W-1:0]   o_last_inliers;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    t_status            trk_status [NUM_SLOTS];
    logic [FRAME_W-1:0] trk_stable [NUM_SLOTS];
    logic [FRAME_W-1:0] trk_unseen [NUM_SLOTS];
    logic [SCORE_W-1:0] trk_score  [NUM_SLOTS];
    logic [COUNT_W-1:0] cfg_min_inl;
    logic [FRAME_W-1:0] cfg_lock;
    logic [FRAME_W-1:0] cfg_max_unseen;

    t_plane_update expected_updates [$];
    int            errors;
    int            cycles;
    int            idle_pct;
    int            stall_pct;
    int            holdoff_left;

    plane_track_lifecycle i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_slot         (i_slot),
        .i_inlier_count (i_inlier_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_slot_out     (o_slot_out),
        .o_plane_status (o_plane_status),
        .o_stable_count (o_stable_count),
        .o_unseen_count (o_unseen_count),
        .o_score_q8     (o_score_q8),
        .o_last_inliers (o_last_inliers),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [FRAME_W-1:0] bump_frames(input logic [FRAME_W-1:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic [SCORE_W-1:0] q8_score(input logic [FRAME_W-1:0] stable);
        int unsigned q;
        if (cfg_lock == 0)
            return SCORE_ONE;
        q = (int'(stable) * 256) / int'(cfg_lock);
        return (q > 256) ? SCORE_ONE : SCORE_W'(q);
    endfunction

    function automatic void age_and_observe(input int s, input logic [COUNT_W-1:0] count);
        t_status st;
        st = trk_status[s];
        trk_unseen[s] = bump_frames(trk_unseen[s]);
        if (count >= cfg_min_inl) begin
            trk_unseen[s] = '0;
            case (st)
                ST_TENTATIVE: begin
                    trk_stable[s] = bump_frames(trk_stable[s]);
                    trk_score[s]  = q8_score(trk_stable[s]);
                    if (trk_stable[s] >= cfg_lock) begin
                        trk_status[s] = ST_LOCKED;
                        trk_score[s]  = SCORE_ONE;
                    end
                end
                ST_TRACKING: begin
                    trk_stable[s] = bump_frames(trk_stable[s]);
                    if (trk_stable[s] >= cfg_lock)
                        trk_status[s] = ST_LOCKED;
                end
                ST_LOST: begin
                    trk_status[s] = ST_TRACKING;
                    trk_stable[s] = 8'd1;
                end
                default: ;
            endcase
        end else begin
            if (st == ST_LOCKED) begin
                trk_status[s] = ST_TRACKING;
                trk_stable[s] = '0;
            end else if (st == ST_TRACKING) begin
                trk_stable[s] = '0;
            end
            if (trk_unseen[s] > cfg_max_unseen)
                trk_status[s] = ST_LOST;
        end
    endfunction

    function automatic void predict_slot_update(input t_mode mode, input logic [SLOT_W-1:0] slot,
                                                input logic [COUNT_W-1:0] count);
        t_plane_update upd;
        int s;
        s = int'(slot);
        upd.inliers = '0;
        case (mode)
            MODE_OBSERVE: begin
                upd.inliers = count;
                age_and_observe(s, count);
            end
            MODE_CREATE: begin
                trk_status[s] = ST_TENTATIVE;
                trk_stable[s] = '0;
                trk_unseen[s] = '0;
                trk_score[s]  = '0;
            end
            MODE_EMPTY: begin
                trk_unseen[s] = bump_frames(trk_unseen[s]);
                age_and_observe(s, '0);
            end
            default: return;
        endcase
        upd.slot   = slot;
        upd.status = trk_status[s];
        upd.stable = trk_stable[s];
        upd.unseen = trk_unseen[s];
        upd.score  = trk_score[s];
        expected_updates = {expected_updates, upd};
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_plane_update want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_updates.size() == 0) begin
                $error("result for slot %0d with no pending request", o_slot_out);
                errors++;
            end else begin
                want = expected_updates.pop_front();
                check_field("slot_out", want.slot, o_slot_out);
                check_field("plane_status", want.status, o_plane_status);
                check_field("stable_count", want.stable, o_stable_count);
                check_field("unseen_count", want.unseen, o_unseen_count);
                check_field("score_q8", want.score, o_score_q8);
                check_field("last_inliers", want.inliers, o_last_inliers);
            end
        end
    end

    always @(negedge i_clk) begin
        if (holdoff_left > 0) begin
            i_out_stall = 1'b1;
            holdoff_left--;
        end else begin
            i_out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_request(input t_mode mode, input logic [SLOT_W-1:0] slot,
                                input logic [COUNT_W-1:0] count);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_mode         = mode;
        i_slot         = slot;
        i_inlier_count = count;
        i_in_valid     = 1'b1;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_slot_update(mode, slot, count);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (expected_updates.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_MIN_INLIERS: cfg_min_inl    = data;
            CFG_LOCK_FRAMES: cfg_lock       = data[FRAME_W-1:0];
            CFG_MAX_UNSEEN:  cfg_max_unseen = data[FRAME_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [11:0] min_inl, input logic [11:0] lock,
                              input logic [11:0] max_unseen);
        wait_idle();
        write_reg(CFG_MIN_INLIERS, min_inl);
        write_reg(CFG_LOCK_FRAMES, lock);
        write_reg(CFG_MAX_UNSEEN, max_unseen);
    endtask

    task automatic random_setting();
        logic [11:0] min_inl;
        logic [11:0] lock;
        logic [11:0] max_unseen;
        min_inl    = ($urandom_range(3) == 0) ? 12'd1 : 12'($urandom_range(300, 1));
        lock       = {4'($urandom), 8'($urandom_range(12, 1))};
        max_unseen = {4'($urandom), 8'($urandom_range(12, 0))};
        set_config(min_inl, lock, max_unseen);
    endtask

    function automatic logic [COUNT_W-1:0] pick_inliers(input int seen_pct);
        if ($urandom_range(9) == 0)
            return COUNT_W'($urandom);
        if (cfg_min_inl == 0 || $urandom_range(99) < seen_pct)
            return COUNT_W'($urandom_range(4095, cfg_min_inl));
        return COUNT_W'($urandom_range(cfg_min_inl - 1, 0));
    endfunction

    task automatic run_random_traffic(input int n);
        int left;
        int focus;
        int seen_pct;
        int len;
        int r;
        t_mode m;
        logic [SLOT_W-1:0] s;
        left = n;
        while (left > 0) begin
            focus    = $urandom_range(NUM_SLOTS - 1);
            seen_pct = $urandom_range(100);
            len      = $urandom_range(40, 5);
            if ($urandom_range(1) == 0) begin
                send_request(MODE_CREATE, SLOT_W'(focus), COUNT_W'($urandom));
                left--;
            end
            for (int k = 0; k < len && left > 0; k++) begin
                r = $urandom_range(99);
                m = (r < 4) ? MODE_CREATE : (r < 8) ? MODE_UNUSED :
                    (r < 22) ? MODE_EMPTY : MODE_OBSERVE;
                s = ($urandom_range(99) < 80) ? SLOT_W'(focus) : SLOT_W'($urandom);
                send_request(m, s, pick_inliers(seen_pct));
                if (m != MODE_UNUSED)
                    left--;
            end
        end
    endtask

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_request(MODE_OBSERVE, 4'd0, 12'd50);
        send_request(MODE_OBSERVE, 4'd0, 12'd49);
        send_request(MODE_EMPTY, 4'd15, 12'd4095);
        send_request(MODE_OBSERVE, 4'd15, 12'd0);
        send_request(MODE_UNUSED, 4'd5, 12'd4095);
        send_request(MODE_CREATE, 4'd1, 12'd4095);
        send_request(MODE_OBSERVE, 4'd1, 12'd4095);
        send_request(MODE_EMPTY, 4'd1, 12'd0);
        set_config(12'd4095, 12'd3, 12'd1);
        send_request(MODE_CREATE, 4'd2, 12'd0);
        repeat (3) send_request(MODE_OBSERVE, 4'd2, 12'd4095);
        send_request(MODE_OBSERVE, 4'd2, 12'd4094);
        send_request(MODE_OBSERVE, 4'd2, 12'd4095);
        send_request(MODE_EMPTY, 4'd2, 12'd0);
        send_request(MODE_OBSERVE, 4'd2, 12'd0);
        set_config(12'd0, 12'd0, 12'd0);
        send_request(MODE_CREATE, 4'd3, 12'd0);
        send_request(MODE_OBSERVE, 4'd3, 12'd0);
        send_request(MODE_EMPTY, 4'd3, 12'd0);
        send_request(MODE_CREATE, 4'd4, 12'd0);
        send_request(MODE_EMPTY, 4'd4, 12'd0);
        send_request(MODE_OBSERVE, 4'd10, 12'd0);
    endtask

    task automatic test_saturation();
        idle_pct  = 6;
        stall_pct = 6;
        set_config(12'd1, 12'hFFF, 12'hFFF);
        send_request(MODE_CREATE, 4'd6, 12'd0);
        repeat (260) send_request(MODE_OBSERVE, 4'd6, 12'($urandom_range(4095, 1)));
        send_request(MODE_CREATE, 4'd7, 12'd0);
        repeat (130) send_request(MODE_EMPTY, 4'd7, 12'($urandom));
        set_config(12'd1, 12'd255, 12'd254);
        send_request(MODE_EMPTY, 4'd7, 12'd0);
    endtask

    task automatic test_random_idling();
        int idle_sel [6] = '{0, 79, 0, 6, 0, 79};
        int stall_sel [6] = '{0, 0, 79, 6, 6, 0};
        for (int p = 0; p < 6; p++) begin
            if (p == 4)
                set_config(12'd4095, 12'd255, 12'd254);
            else if (p == 5)
                set_config(12'd0, 12'd1, 12'd0);
            else
                random_setting();
            idle_pct  = idle_sel[p];
            stall_pct = stall_sel[p];
            run_random_traffic(200);
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_reg(CFG_NONE, 12'($urandom));
        random_setting();
        idle_pct  = 0;
        stall_pct = 0;
        @(posedge i_clk);
        holdoff_left = HOLDOFF_LEN;
        @(negedge i_clk);
        run_random_traffic(60);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_mode         = MODE_OBSERVE;
        i_slot         = '0;
        i_inlier_count = '0;
        i_out_stall    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_MIN_INLIERS;
        i_cfg_data     = '0;
        errors         = 0;
        cycles         = 0;
        idle_pct       = 0;
        stall_pct      = 0;
        holdoff_left   = 0;
        cfg_min_inl    = MIN_INLIERS_RST;
        cfg_lock       = LOCK_FRAMES_RST;
        cfg_max_unseen = MAX_UNSEEN_RST;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            trk_status[i] = ST_LOST;
            trk_stable[i] = '0;
            trk_unseen[i] = '0;
            trk_score[i]  = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_saturation();
        test_random_idling();
        test_backpressure();

        wait_idle();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
